[rtl/core/spp_pkg.sv]
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants of the stepper ramp segment planner.
// ----------------------------------------------------------------------------
`default_nettype none
package spp_pkg;

    localparam int PROFILE_MAX = 8;
    localparam int MAG_W       = 21;
    localparam int FACTOR_W    = 9;
    localparam int CFG16_W     = 16;
    localparam int PLEN_W      = 4;
    localparam int WORD_W      = 64;
    localparam int SEG_W       = 25;   // steps_per_segment * factor
    localparam int P1_W        = 37;   // mag * steps_per_rev
    localparam int PROD_W      = 46;   // mag * steps_per_rev * factor + 180
    localparam int TOTAL_W     = 38;
    localparam int MID_W       = 40;
    localparam int RAMP_W      = 30;
    localparam int DVS_W       = 27;
    localparam int REM_W       = 26;
    localparam int CNT_W       = 6;
    localparam int IDX_W       = 3;
    localparam int STEPS_W     = 38;
    localparam int PERIOD_W    = 20;
    localparam int PPROD_W     = 32;
    localparam int CFG_IDX_W   = 3;

    // divide by 360, one 12-bit digit at a time
    localparam int CNUM_W      = 48;   // dividend padded to whole digits
    localparam int CDIG_W      = 12;
    localparam int CT_W        = 21;   // remainder and digit window
    localparam int CPROD_W     = 45;
    localparam int CREM_W      = 9;

    localparam logic [8:0]        DEG_FULL  = 9'd360;
    localparam logic [7:0]        DEG_HALF  = 8'd180;
    localparam logic [PPROD_W:0]  ROUND_Q12 = 33'd2048;
    // ceil(2^32 / 360); exact quotient for any window below 2^21
    localparam logic [23:0]       RECIP_360 = 24'd11930465;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEPS_PER_REV  = 3'd0,
        CFG_STEPS_PER_SEG  = 3'd1,
        CFG_BASE_PERIOD    = 3'd2,
        CFG_PROFILE_LEN    = 3'd3,
        CFG_PROFILE_LOW    = 3'd4,
        CFG_PROFILE_HIGH   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DIVT_GO,
        S_DIVT_WAIT,
        S_MID,
        S_DECIDE,
        S_DIVC_GO,
        S_DIVC_WAIT,
        S_CUT,
        S_PMUL,
        S_PUT
    } t_state;

    typedef enum logic [1:0] {
        PH_UP,
        PH_CRUISE,
        PH_DOWN
    } t_phase;

    typedef struct packed {
        logic             load_in;
        logic             mul1;
        logic             mul2;
        logic             div_go;
        logic             div_sel_cut;
        logic             take_total;
        logic             calc_mid;
        logic             take_cut;
        logic             cut_len;
        logic             pmul;
        logic             load_out;
        logic             out_cruise;
        logic             out_last;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic        div_busy;
        logic        mid_neg;
        logic        mid_pos;
        logic [3:0]  cut;
        logic        out_free;
    } t_sts;

endpackage
`default_nettype wire

[rtl/core/spp_ctrl.sv]
// ----------------------------------------------------------------------------
// spp_ctrl
// Sequencer: arithmetic steps of a move, then the walk over the segments.
// ----------------------------------------------------------------------------
`default_nettype none
module spp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  spp_pkg::t_sts       i_sts,
    output logic                o_idle,
    output spp_pkg::t_cmd       o_cmd
);

    spp_pkg::t_state r_state, n_state;
    spp_pkg::t_phase r_phase, n_phase;
    logic [spp_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [spp_pkg::IDX_W-1:0] w_top;

    assign w_top = spp_pkg::IDX_W'(i_sts.cut - 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spp_pkg::S_IDLE;
            r_phase <= spp_pkg::PH_UP;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_idx   = r_idx;
        case (r_state)
            spp_pkg::S_IDLE:      if (i_accept) n_state = spp_pkg::S_MUL1;
            spp_pkg::S_MUL1:      n_state = spp_pkg::S_MUL2;
            spp_pkg::S_MUL2:      n_state = spp_pkg::S_DIVT_GO;
            spp_pkg::S_DIVT_GO:   n_state = spp_pkg::S_DIVT_WAIT;
            spp_pkg::S_DIVT_WAIT: if (!i_sts.div_busy) n_state = spp_pkg::S_MID;
            spp_pkg::S_MID:       n_state = spp_pkg::S_DECIDE;
            spp_pkg::S_DECIDE: begin
                n_phase = spp_pkg::PH_UP;
                n_idx   = '0;
                n_state = i_sts.mid_neg ? spp_pkg::S_DIVC_GO : spp_pkg::S_PMUL;
            end
            spp_pkg::S_DIVC_GO:   n_state = spp_pkg::S_DIVC_WAIT;
            spp_pkg::S_DIVC_WAIT: if (!i_sts.div_busy) n_state = spp_pkg::S_CUT;
            spp_pkg::S_CUT:       n_state = spp_pkg::S_PMUL;
            spp_pkg::S_PMUL: begin
                // empty plan when the cut comes out zero
                if (i_sts.cut == 4'd0) n_state = spp_pkg::S_IDLE;
                else                   n_state = spp_pkg::S_PUT;
            end
            spp_pkg::S_PUT: begin
                if (i_sts.out_free) begin
                    n_state = spp_pkg::S_PMUL;
                    case (r_phase)
                        spp_pkg::PH_UP: begin
                            if (r_idx == w_top)
                                n_phase = i_sts.mid_pos ? spp_pkg::PH_CRUISE
                                                        : spp_pkg::PH_DOWN;
                            else
                                n_idx = r_idx + 1'b1;
                        end
                        spp_pkg::PH_CRUISE: n_phase = spp_pkg::PH_DOWN;
                        default: begin
                            if (r_idx == '0) n_state = spp_pkg::S_IDLE;
                            else             n_idx = r_idx - 1'b1;
                        end
                    endcase
                end
            end
            default: n_state = spp_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd             = '0;
        o_cmd.idx         = r_idx;
        o_cmd.load_in     = (r_state == spp_pkg::S_IDLE) && i_accept;
        o_cmd.mul1        = (r_state == spp_pkg::S_MUL1);
        o_cmd.mul2        = (r_state == spp_pkg::S_MUL2);
        o_cmd.div_go      = (r_state == spp_pkg::S_DIVT_GO) ||
                            (r_state == spp_pkg::S_DIVC_GO);
        o_cmd.div_sel_cut = (r_state == spp_pkg::S_DIVC_GO);
        o_cmd.take_total  = (r_state == spp_pkg::S_DIVT_WAIT) && !i_sts.div_busy;
        o_cmd.calc_mid    = (r_state == spp_pkg::S_MID);
        o_cmd.cut_len     = (r_state == spp_pkg::S_DECIDE) && !i_sts.mid_neg;
        o_cmd.take_cut    = (r_state == spp_pkg::S_CUT);
        o_cmd.pmul        = (r_state == spp_pkg::S_PMUL);
        o_cmd.load_out    = (r_state == spp_pkg::S_PUT) && i_sts.out_free;
        o_cmd.out_cruise  = (r_phase == spp_pkg::PH_CRUISE);
        o_cmd.out_last    = (r_phase == spp_pkg::PH_DOWN) && (r_idx == '0);
    end

    assign o_idle = (r_state == spp_pkg::S_IDLE);

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("segment loaded over a pending beat");

    a_idx_in_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spp_pkg::S_PUT) |-> ({1'b0, r_idx} < i_sts.cut))
        else $error("segment index beyond cut");

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spp_pkg::S_IDLE) |-> !i_sts.div_busy)
        else $error("divider running while idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out && o_cmd.out_last) |=> (r_state == spp_pkg::S_IDLE))
        else $error("plan continued after last segment");

endmodule
`default_nettype wire

[rtl/core/spp_dp.sv]
// ----------------------------------------------------------------------------
// spp_dp
// Datapath: config registers, multipliers, dividers, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module spp_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [spp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [spp_pkg::WORD_W-1:0]    i_cfg_data,
    input  wire logic [spp_pkg::MAG_W-1:0]     i_move_degrees,
    input  wire logic [spp_pkg::FACTOR_W-1:0]  i_factor,
    input  spp_pkg::t_cmd                      i_cmd,
    output spp_pkg::t_sts                      o_sts,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic [spp_pkg::STEPS_W-1:0]        o_steps,
    output logic [spp_pkg::PERIOD_W-1:0]       o_period,
    output logic                               o_last
);

    logic [spp_pkg::CFG16_W-1:0] r_spr, r_sps, r_base;
    logic [spp_pkg::PLEN_W-1:0]  r_plen;
    logic [spp_pkg::WORD_W-1:0]  r_plo, r_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr  <= 16'd200;
            r_sps  <= 16'd10;
            r_base <= 16'd1000;
            r_plen <= 4'd1;
            r_plo  <= 64'd4096;
            r_phi  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spp_pkg::CFG_STEPS_PER_REV: r_spr  <= i_cfg_data[15:0];
                spp_pkg::CFG_STEPS_PER_SEG: r_sps  <= i_cfg_data[15:0];
                spp_pkg::CFG_BASE_PERIOD:   r_base <= i_cfg_data[15:0];
                spp_pkg::CFG_PROFILE_LEN:   r_plen <= i_cfg_data[3:0];
                spp_pkg::CFG_PROFILE_LOW:   r_plo  <= i_cfg_data;
                spp_pkg::CFG_PROFILE_HIGH:  r_phi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [3:0] w_len;
    always_comb begin
        if (r_plen == 4'd0)                   w_len = 4'd1;
        else if (r_plen > 4'(spp_pkg::PROFILE_MAX)) w_len = 4'(spp_pkg::PROFILE_MAX);
        else                                  w_len = r_plen;
    end

    logic [spp_pkg::MAG_W-1:0]    r_mag;
    logic                         r_dir_neg;
    logic [spp_pkg::FACTOR_W-1:0] r_factor;
    logic [spp_pkg::P1_W-1:0]     r_p1;
    logic [spp_pkg::SEG_W-1:0]    r_seg;
    logic [spp_pkg::PROD_W-1:0]   r_prod;
    logic [spp_pkg::TOTAL_W-1:0]  r_total;
    logic signed [spp_pkg::MID_W-1:0] r_mid;
    logic [3:0]                   r_cut;
    logic [spp_pkg::PPROD_W-1:0]  r_pprod;
    logic [spp_pkg::RAMP_W-1:0]   w_ramp;

    assign w_ramp = spp_pkg::RAMP_W'({r_seg, 1'b0} * w_len);

    // divide by 360: per digit, reciprocal multiply, then the remainder
    logic [spp_pkg::CNUM_W-1:0]  r_cnum;
    logic [spp_pkg::CNUM_W-1:0]  r_cquo;
    logic [spp_pkg::CREM_W-1:0]  r_crem;
    logic [spp_pkg::CDIG_W-1:0]  r_cq;
    logic [1:0]                  r_ccnt;
    logic                        r_cph;
    logic                        r_cbusy;
    logic [spp_pkg::CT_W-1:0]    w_ct;
    logic [spp_pkg::CPROD_W-1:0] w_cprod;
    logic [spp_pkg::CT_W-1:0]    w_cdiff;
    logic                        w_cgo;

    assign w_cgo   = i_cmd.div_go && !i_cmd.div_sel_cut;
    assign w_ct    = {r_crem, r_cnum[spp_pkg::CNUM_W-1 -: spp_pkg::CDIG_W]};
    assign w_cprod = {24'd0, w_ct} * {21'd0, spp_pkg::RECIP_360};
    assign w_cdiff = w_ct - ({9'd0, r_cq} * {12'd0, spp_pkg::DEG_FULL});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbusy <= 1'b0;
            r_cph   <= 1'b0;
            r_ccnt  <= '0;
        end else if (w_cgo) begin
            r_cbusy <= 1'b1;
            r_cph   <= 1'b0;
            r_ccnt  <= '0;
        end else if (r_cbusy) begin
            r_cph <= !r_cph;
            if (r_cph) begin
                r_ccnt <= r_ccnt + 1'b1;
                if (r_ccnt == 2'd3) r_cbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cgo) begin
            r_cnum <= spp_pkg::CNUM_W'(r_prod) + spp_pkg::CNUM_W'(spp_pkg::DEG_HALF);
            r_crem <= '0;
        end else if (r_cbusy) begin
            if (!r_cph) begin
                r_cq <= w_cprod[32 +: spp_pkg::CDIG_W];
            end else begin
                r_crem <= w_cdiff[spp_pkg::CREM_W-1:0];
                r_cquo <= {r_cquo[spp_pkg::CNUM_W-spp_pkg::CDIG_W-1:0], r_cq};
                r_cnum <= {r_cnum[spp_pkg::CNUM_W-spp_pkg::CDIG_W-1:0],
                           {spp_pkg::CDIG_W{1'b0}}};
            end
        end
    end

    // restoring divider for the ramp cut, one quotient bit per cycle
    logic [spp_pkg::PROD_W-1:0] r_quo;
    logic [spp_pkg::REM_W-1:0]  r_rem;
    logic [spp_pkg::DVS_W-1:0]  r_dvs;
    logic [spp_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_busy;
    logic [spp_pkg::DVS_W-1:0]  w_trial;
    logic                       w_ge;
    logic                       w_sgo;

    assign w_sgo   = i_cmd.div_go && i_cmd.div_sel_cut;
    assign w_trial = {r_rem, r_quo[spp_pkg::PROD_W-1]};
    assign w_ge    = (w_trial >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_sgo) begin
            r_busy <= 1'b1;
            r_cnt  <= spp_pkg::CNT_W'(spp_pkg::PROD_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == spp_pkg::CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sgo) begin
            r_rem <= '0;
            r_quo <= spp_pkg::PROD_W'({1'b0, r_total} + {14'd0, r_seg});
            r_dvs <= {1'b0, r_seg, 1'b0};
        end else if (r_busy) begin
            r_rem <= w_ge ? spp_pkg::REM_W'(w_trial - r_dvs) : w_trial[spp_pkg::REM_W-1:0];
            r_quo <= {r_quo[spp_pkg::PROD_W-2:0], w_ge};
        end
    end

    logic [15:0] w_mult;
    always_comb begin
        case (i_cmd.idx)
            3'd0:    w_mult = r_plo[15:0];
            3'd1:    w_mult = r_plo[31:16];
            3'd2:    w_mult = r_plo[47:32];
            3'd3:    w_mult = r_plo[63:48];
            3'd4:    w_mult = r_phi[15:0];
            3'd5:    w_mult = r_phi[31:16];
            3'd6:    w_mult = r_phi[47:32];
            default: w_mult = r_phi[63:48];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mag     <= i_move_degrees[spp_pkg::MAG_W-1]
                         ? spp_pkg::MAG_W'(-i_move_degrees) : i_move_degrees;
            r_dir_neg <= i_move_degrees[spp_pkg::MAG_W-1] || (i_move_degrees == '0);
            r_factor  <= i_factor;
        end
        if (i_cmd.mul1) begin
            r_p1  <= spp_pkg::P1_W'(r_mag * r_spr);
            r_seg <= spp_pkg::SEG_W'(r_sps * r_factor);
        end
        if (i_cmd.mul2)       r_prod  <= spp_pkg::PROD_W'(r_p1 * r_factor);
        if (i_cmd.take_total) r_total <= r_cquo[spp_pkg::TOTAL_W-1:0];
        if (i_cmd.calc_mid)
            r_mid <= $signed({2'b00, r_total}) - $signed({10'd0, w_ramp});
        if (i_cmd.cut_len)    r_cut <= w_len;
        if (i_cmd.take_cut)
            r_cut <= (r_quo > spp_pkg::PROD_W'(w_len)) ? w_len : r_quo[3:0];
        if (i_cmd.pmul)       r_pprod <= spp_pkg::PPROD_W'(r_base * w_mult);
    end

    // output beat register
    logic [spp_pkg::STEPS_W-1:0]  w_smag;
    logic [spp_pkg::PPROD_W:0]    w_pround;
    assign w_smag   = i_cmd.out_cruise ? r_mid[spp_pkg::STEPS_W-1:0]
                                       : spp_pkg::STEPS_W'(r_seg);
    assign w_pround = {1'b0, r_pprod} + spp_pkg::ROUND_Q12;

    logic r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_valid <= 1'b0;
        else if (i_cmd.load_out) r_valid <= 1'b1;
        else if (i_m_tready)     r_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_steps  <= r_dir_neg ? spp_pkg::STEPS_W'(-w_smag) : w_smag;
            o_period <= w_pround[12 +: spp_pkg::PERIOD_W];
            o_last   <= i_cmd.out_last;
        end
    end

    assign o_m_tvalid     = r_valid;
    assign o_sts.div_busy = r_busy || r_cbusy;
    assign o_sts.mid_neg  = r_mid[spp_pkg::MID_W-1];
    assign o_sts.mid_pos  = !r_mid[spp_pkg::MID_W-1] && (r_mid != '0);
    assign o_sts.cut      = r_cut;
    assign o_sts.out_free = !r_valid || i_m_tready;

endmodule
`default_nettype wire

[rtl/core/stepper_ramp_segment_planner.sv]
// ----------------------------------------------------------------------------
// stepper_ramp_segment_planner
// Turns a move command into a trapezoidal run of (steps, period) segments.
// ----------------------------------------------------------------------------
// Slave stream: one beat per move. tdata holds move_degrees (signed, 21 bit)
// then microstep_factor (9 bit). tready is high only while no move is in work.
// Master stream: one beat per segment, tlast on the final one of a plan; a
// cut of zero gives no beat at all.
// From the accepting edge to the first valid segment a move runs through two
// multiplies, the divide by 360 in four 12-bit digits, mid and decide, then
// period multiply and beat load; a cut ramp adds the serial cut divide
// between decide and period multiply. Each further segment takes a period
// multiply and a beat load. A move gives at most 17 segments, or 16 with a
// cut ramp; the slave side is freed once the last one is loaded. The serial
// cut divider and the segment walk set the pace.
// A stalled receiver holds the segment walk: the next segment waits in the
// datapath until the output register is free. The output register lets the
// next beat load in the same cycle the current one is taken.
// Reset (synchronous, active low) restores the register defaults, drops any
// move in work and clears the output valid. The user must make config writes
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module stepper_ramp_segment_planner (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [20:0] move_degrees, [29:21] microstep_factor
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // [37:0] segment_steps, [57:38] segment_period_us
    output logic             o_m_tlast
);

    spp_pkg::t_cmd w_cmd;
    spp_pkg::t_sts w_sts;
    logic          w_idle;
    logic          w_accept;
    logic [spp_pkg::STEPS_W-1:0]  w_steps;
    logic [spp_pkg::PERIOD_W-1:0] w_period;

    assign o_s_tready = w_idle;
    assign w_accept   = i_s_tvalid && w_idle;

    spp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_sts    (w_sts),
        .o_idle   (w_idle),
        .o_cmd    (w_cmd)
    );

    spp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_move_degrees (i_s_tdata[20:0]),
        .i_factor       (i_s_tdata[29:21]),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_steps        (w_steps),
        .o_period       (w_period),
        .o_last         (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, w_period, w_steps};

endmodule
`default_nettype wire

[sim/spp_plan_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spp_plan_checker
// Watches both streams of the planner, works out the segment plan of every
// accepted move and compares each segment beat against it, in order.
// ----------------------------------------------------------------------------
module spp_plan_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [spp_pkg::STEPS_W-1:0]  steps;
        logic [spp_pkg::PERIOD_W-1:0] period;
        logic                         last;
    } t_segment;

    t_segment   plan_q[$];
    logic [15:0] spr, sps, base;
    logic [3:0]  plen;
    logic [63:0] prof_lo, prof_hi;

    function automatic logic [spp_pkg::PERIOD_W-1:0] entry_period(int unsigned i);
        logic [63:0] w;
        logic [15:0] mult;
        logic [63:0] p;
        w    = (i < 4) ? prof_lo : prof_hi;
        mult = w[16*(i%4) +: 16];
        p    = ({48'd0, base} * {48'd0, mult} + 64'd2048) >> 12;
        return p[spp_pkg::PERIOD_W-1:0];
    endfunction

    function automatic void queue_segment(input t_segment s);
        plan_q.insert(plan_q.size(), s);
    endfunction

    task automatic plan_move(input logic [20:0] deg, input logic [8:0] fac);
        logic [63:0]  mag, total, seg, ramp, cut, len;
        logic signed [63:0] mid, dir, segs;
        int n, cnt, ncut;
        mag = deg[20] ? {43'd0, (~deg + 21'd1)} : {43'd0, deg};
        dir = (!deg[20] && deg != 21'd0) ? 64'sd1 : -64'sd1;
        len = (plen == 4'd0) ? 64'd1 :
              (plen > 4'(spp_pkg::PROFILE_MAX)) ? 64'(spp_pkg::PROFILE_MAX) : 64'(plen);
        total = (mag * spr * fac + 64'd180) / 64'd360;
        seg   = sps * fac;
        ramp  = 64'd2 * len * seg;
        mid   = $signed(total) - $signed(ramp);
        if (mid >= 0) cut = len;
        else begin
            cut = (total + seg) / (64'd2 * seg);
            if (cut > len) cut = len;
        end
        if (cut == 64'd0) return;
        ncut = int'(cut);
        segs = $signed(seg) * dir;
        cnt  = 2 * ncut + ((mid > 0) ? 1 : 0);
        n    = 0;
        for (int i = 0; i < ncut; i++) begin
            queue_segment('{segs[spp_pkg::STEPS_W-1:0], entry_period(i), n == cnt - 1});
            n++;
        end
        if (mid > 0) begin
            segs = mid * dir;
            queue_segment('{segs[spp_pkg::STEPS_W-1:0], entry_period(ncut - 1),
                            n == cnt - 1});
            segs = $signed(seg) * dir;
            n++;
        end
        for (int i = ncut; i > 0; i--) begin
            queue_segment('{segs[spp_pkg::STEPS_W-1:0], entry_period(i - 1), n == cnt - 1});
            n++;
        end
    endtask

    always @(posedge i_clk) begin
        t_segment want, got;
        if (!i_rst_n) begin
            spr <= 16'd200; sps <= 16'd10; base <= 16'd1000; plen <= 4'd1;
            prof_lo <= 64'd4096; prof_hi <= 64'd0;
            o_errors  <= 0;
            o_pending <= 0;
            plan_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (spp_pkg::t_cfg_idx'(i_cfg_idx))
                    spp_pkg::CFG_STEPS_PER_REV: spr     <= i_cfg_data[15:0];
                    spp_pkg::CFG_STEPS_PER_SEG: sps     <= i_cfg_data[15:0];
                    spp_pkg::CFG_BASE_PERIOD:   base    <= i_cfg_data[15:0];
                    spp_pkg::CFG_PROFILE_LEN:   plen    <= i_cfg_data[3:0];
                    spp_pkg::CFG_PROFILE_LOW:   prof_lo <= i_cfg_data;
                    spp_pkg::CFG_PROFILE_HIGH:  prof_hi <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tdata[37:0], i_m_tdata[57:38], i_m_tlast};
                if (plan_q.size() == 0) begin
                    $display("%0t: unexpected segment, exp none, got %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = plan_q.pop_front();
                    if (want != got) begin
                        $display("%0t: segment mismatch exp steps %h period %0d last %b,",
                                 $time, want.steps, want.period, want.last);
                        $display("    got steps %h period %0d last %b",
                                 got.steps, got.period, got.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) plan_move(i_s_tdata[20:0], i_s_tdata[29:21]);
            o_pending <= plan_q.size();
        end
    end

endmodule

[sim/tb_stepper_ramp_segment_planner.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_ramp_segment_planner
// Drives moves through the planner under several register settings with
// random gaps and back-pressure; the checker compares every segment beat.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_segment_planner;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [63:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    int          errors, pending;
    int          cycles = 0;
    bit          sink_on = 1'b0;

    always #4 i_clk = ~i_clk;

    stepper_ramp_segment_planner u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tlast(m_tlast)
    );

    spp_plan_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tlast(m_tlast), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("[stepper_ramp_segment_planner] ERROR");
            $finish;
        end
    end

    // receiver: random stall before each beat
    initial begin
        int w;
        wait (sink_on);
        forever begin
            w = $urandom_range(0, 6);
            @(negedge i_clk);
            if (w == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                repeat (w) @(negedge i_clk);
                m_tready <= 1'b1;
            end
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    task automatic write_reg(input spp_pkg::t_cfg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_move(input logic [20:0] deg, input logic [8:0] fac, input bit gap);
        if (gap) repeat ($urandom_range(0, 6)) @(negedge i_clk);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, fac, deg};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_moves(input int n);
        logic [20:0] deg;
        logic [8:0]  fac;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
                0: deg = 21'($urandom);
                1: deg = 21'($urandom_range(0, 2000));
                2: deg = 21'(-$urandom_range(0, 2000));
                default: deg = 21'($urandom_range(0, 40000) - 20000);
            endcase
            fac = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(1, 16));
            send_move(deg, fac, k % 40 < 30);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1'b1;

        // reset settings: zero angle, extremes, rounding edges, cut of zero
        send_move(21'd0, 9'd1, 1'b0);
        send_move(21'd1, 9'd1, 1'b0);
        send_move(21'h1FFFFF, 9'd1, 1'b0);
        send_move(21'h0FFFFF, 9'd256, 1'b0);
        send_move(21'h100000, 9'd256, 1'b0);
        send_move(21'h100000, 9'h1FF, 1'b0);
        send_move(21'd36, 9'd1, 1'b0);
        send_move(21'd27, 9'd1, 1'b0);
        send_move(21'd9, 9'd1, 1'b0);
        send_move(21'd0, 9'd0, 1'b0);
        send_move(21'd720, 9'd0, 1'b0);
        random_moves(60);
        drain();

        // full 8-entry profile, length register above the maximum later
        write_reg(spp_pkg::CFG_STEPS_PER_REV, 64'd400);
        write_reg(spp_pkg::CFG_STEPS_PER_SEG, 64'd2);
        write_reg(spp_pkg::CFG_BASE_PERIOD, 64'd65535);
        write_reg(spp_pkg::CFG_PROFILE_LEN, 64'd8);
        write_reg(spp_pkg::CFG_PROFILE_LOW, 64'hFFFF_C000_2000_1000);
        write_reg(spp_pkg::CFG_PROFILE_HIGH, 64'h0800_0001_0000_F123);
        send_move(21'd72, 9'd1, 1'b0);
        send_move(-21'd14, 9'd1, 1'b0);
        send_move(21'd15, 9'd1, 1'b0);
        random_moves(90);
        drain();

        write_reg(spp_pkg::CFG_PROFILE_LEN, 64'd15);
        write_reg(spp_pkg::CFG_STEPS_PER_SEG, 64'd0);
        send_move(21'd100, 9'd3, 1'b0);
        send_move(21'd0, 9'd3, 1'b0);
        random_moves(30);
        drain();

        write_reg(spp_pkg::CFG_PROFILE_LEN, 64'd0);
        write_reg(spp_pkg::CFG_STEPS_PER_SEG, 64'd65535);
        write_reg(spp_pkg::CFG_STEPS_PER_REV, 64'd65535);
        write_reg(spp_pkg::CFG_BASE_PERIOD, 64'd1);
        write_reg(spp_pkg::CFG_PROFILE_LOW, {$urandom, $urandom});
        random_moves(70);
        drain();

        write_reg(spp_pkg::CFG_STEPS_PER_REV, 64'd1);
        write_reg(spp_pkg::CFG_STEPS_PER_SEG, 64'd1);
        write_reg(spp_pkg::CFG_PROFILE_LEN, 64'd5);
        write_reg(spp_pkg::CFG_BASE_PERIOD, 64'd12345);
        write_reg(spp_pkg::CFG_PROFILE_HIGH, {$urandom, $urandom});
        random_moves(70);
        drain();

        write_reg(spp_pkg::CFG_STEPS_PER_REV, 64'd200);
        write_reg(spp_pkg::CFG_STEPS_PER_SEG, 64'd5);
        write_reg(spp_pkg::CFG_PROFILE_LEN, 64'd4);
        write_reg(spp_pkg::CFG_PROFILE_LOW, {$urandom, $urandom});
        write_reg(spp_pkg::CFG_PROFILE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        random_moves(70);
        drain();

        if (errors == 0) begin
            $display("[stepper_ramp_segment_planner] OK");
        end else begin
            $display("[stepper_ramp_segment_planner] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/spp_pkg.sv
rtl/core/spp_ctrl.sv
rtl/core/spp_dp.sv
rtl/core/stepper_ramp_segment_planner.sv
sim/spp_plan_checker.sv
sim/tb_stepper_ramp_segment_planner.sv
